// File: hdl/mi3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_pkg
// Types and widths shared by the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int N_ENT  = 9;
  localparam int ENT_W  = 32;
  localparam int COF_W  = 64;
  localparam int PLO_W  = COF_W + 1;
  localparam int DET_W  = 100;
  localparam int REM_W  = DET_W + 1;
  localparam int QUO_W  = 32;
  localparam int HALF_W = COF_W / 2;

  typedef logic signed [ENT_W-1:0] ent_t;
  typedef logic signed [COF_W-1:0] cof_t;
  typedef logic signed [DET_W-1:0] det_t;
  typedef logic        [DET_W-1:0] dmag_t;
  typedef logic        [REM_W-1:0] rem_t;
  typedef logic        [QUO_W-1:0] quo_t;
  typedef logic        [COF_W-1:0] mag_t;

  localparam ent_t SAT_POS = {1'b0, {(ENT_W-1){1'b1}}};
  localparam ent_t SAT_NEG = {1'b1, {(ENT_W-1){1'b0}}};
  localparam det_t DET_ONE = det_t'(64'h1_0000_0000);

endpackage

// File: hdl/matrix3_inverse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3_inverse
// Pipelined 3x3 inverse in signed Q16.16 via adjugate and long division.
// ----------------------------------------------------------------------------
// One matrix enters per clock unless the output stalls. Each transaction
// passes through one input register, six stages for the cofactor
// products, cofactors, determinant partial products, determinant sum,
// magnitudes and overflow check, then 32 stages of a restoring divider, one
// quotient bit per stage, and the output register. With is_rotation set the
// transpose is passed through the same pipeline unchanged. A stall at the
// output holds the whole pipeline.
module matrix3_inverse (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mi3_pkg::ent_t      in_col0_row0,
  input  mi3_pkg::ent_t      in_col0_row1,
  input  mi3_pkg::ent_t      in_col0_row2,
  input  mi3_pkg::ent_t      in_col1_row0,
  input  mi3_pkg::ent_t      in_col1_row1,
  input  mi3_pkg::ent_t      in_col1_row2,
  input  mi3_pkg::ent_t      in_col2_row0,
  input  mi3_pkg::ent_t      in_col2_row1,
  input  mi3_pkg::ent_t      in_col2_row2,
  input  logic               in_is_rotation,
  output logic               out_valid,
  input  logic               out_stall,
  output mi3_pkg::ent_t      out_inv_col0_row0,
  output mi3_pkg::ent_t      out_inv_col0_row1,
  output mi3_pkg::ent_t      out_inv_col0_row2,
  output mi3_pkg::ent_t      out_inv_col1_row0,
  output mi3_pkg::ent_t      out_inv_col1_row1,
  output mi3_pkg::ent_t      out_inv_col1_row2,
  output mi3_pkg::ent_t      out_inv_col2_row0,
  output mi3_pkg::ent_t      out_inv_col2_row1,
  output mi3_pkg::ent_t      out_inv_col2_row2,
  output logic               out_singular
);
  import mi3_pkg::*;

  logic en;
  ent_t in_ent [N_ENT];

  // stage 0: input
  logic v0_r, rot0_r;
  ent_t ent0_r [N_ENT];
  // stage 1: cofactor products
  logic v1_r, rot1_r;
  ent_t ent1_r [N_ENT];
  cof_t pa1_r [N_ENT];
  cof_t pb1_r [N_ENT];
  // stage 2: cofactors
  logic v2_r, rot2_r;
  ent_t row2_r [3];
  cof_t cof2_r [N_ENT];
  // stage 3: determinant partial products
  logic v3_r, rot3_r;
  cof_t cof3_r [N_ENT];
  logic signed [COF_W-1:0] phi3_r [3];
  logic signed [PLO_W-1:0] plo3_r [3];
  // stage 4: determinant
  logic v4_r;
  det_t det4_r;
  cof_t cof4_r [N_ENT];
  // stage 5: magnitudes
  logic  v5_r, zero5_r;
  dmag_t dmag5_r;
  mag_t  mag5_r [N_ENT];
  logic  neg5_r [N_ENT];
  // divider stages, index 0 holds the overflow check
  logic  vd_r    [QUO_W+1];
  logic  zerod_r [QUO_W+1];
  dmag_t dmagd_r [QUO_W+1];
  rem_t  remd_r  [QUO_W+1][N_ENT];
  quo_t  quod_r  [QUO_W+1][N_ENT];
  logic  ovfd_r  [QUO_W+1][N_ENT];
  logic  negd_r  [QUO_W+1][N_ENT];
  rem_t  rem_nxt [QUO_W][N_ENT];
  logic  ge_nxt  [QUO_W][N_ENT];
  // output
  logic  out_valid_r, out_singular_r;
  ent_t  res_r  [N_ENT];
  ent_t  res_nxt[N_ENT];

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  assign in_ent[0] = in_col0_row0;
  assign in_ent[1] = in_col0_row1;
  assign in_ent[2] = in_col0_row2;
  assign in_ent[3] = in_col1_row0;
  assign in_ent[4] = in_col1_row1;
  assign in_ent[5] = in_col1_row2;
  assign in_ent[6] = in_col2_row0;
  assign in_ent[7] = in_col2_row1;
  assign in_ent[8] = in_col2_row2;

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int s = 0; s <= QUO_W; s++) vd_r[s] <= 1'b0;
    end else if (en) begin
      v0_r        <= in_valid;
      v1_r        <= v0_r;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      vd_r[0]     <= v5_r;
      for (int s = 0; s < QUO_W; s++) vd_r[s+1] <= vd_r[s];
      out_valid_r <= vd_r[QUO_W];
    end
  end

  // stages 0 to 2
  always_ff @(posedge clk) begin
    if (en) begin
      rot0_r <= in_is_rotation;
      ent0_r <= in_ent;
      rot1_r <= rot0_r;
      ent1_r <= ent0_r;
      rot2_r <= rot1_r;
      for (int c = 0; c < 3; c++) row2_r[c] <= ent1_r[3*c];
    end
  end

  // entry at row i, column j sits at 3*j + i
  for (genvar c = 0; c < 3; c++) begin : g_col
    for (genvar r = 0; r < 3; r++) begin : g_row
      localparam int K  = 3*c + r;
      localparam int I1 = (c + 1) % 3;
      localparam int I2 = (c + 2) % 3;
      localparam int J1 = (r + 1) % 3;
      localparam int J2 = (r + 2) % 3;
      always_ff @(posedge clk) begin
        if (en) begin
          pa1_r[K] <= cof_t'(ent0_r[3*J1+I1]) * cof_t'(ent0_r[3*J2+I2]);
          pb1_r[K] <= cof_t'(ent0_r[3*J2+I1]) * cof_t'(ent0_r[3*J1+I2]);
          cof2_r[K] <= rot1_r ? cof_t'(ent1_r[3*r+c]) : pa1_r[K] - pb1_r[K];
        end
      end
    end
  end

  // stages 3 to 5
  always_ff @(posedge clk) begin
    det_t sum;
    if (en) begin
      rot3_r <= rot2_r;
      cof3_r <= cof2_r;
      for (int c = 0; c < 3; c++) begin
        phi3_r[c] <= cof_t'(row2_r[c]) * cof_t'($signed(cof2_r[c][COF_W-1:HALF_W]));
        plo3_r[c] <= PLO_W'(row2_r[c]) * $signed({1'b0, cof2_r[c][HALF_W-1:0]});
      end
      sum = '0;
      for (int c = 0; c < 3; c++)
        sum = sum + (det_t'(phi3_r[c]) <<< HALF_W) + det_t'(plo3_r[c]);
      det4_r <= rot3_r ? DET_ONE : sum;
      cof4_r <= cof3_r;
      zero5_r <= (det4_r == '0);
      dmag5_r <= det4_r[DET_W-1] ? dmag_t'(-det4_r) : dmag_t'(det4_r);
      for (int k = 0; k < N_ENT; k++) begin
        mag5_r[k] <= cof4_r[k][COF_W-1] ? mag_t'(-cof4_r[k]) : mag_t'(cof4_r[k]);
        neg5_r[k] <= cof4_r[k][COF_W-1] ^ det4_r[DET_W-1];
      end
    end
  end

  // divider
  always_comb begin
    rem_t t;
    for (int s = 0; s < QUO_W; s++) begin
      for (int k = 0; k < N_ENT; k++) begin
        t = {remd_r[s][k][REM_W-2:0], 1'b0};
        ge_nxt[s][k]  = (t >= {1'b0, dmagd_r[s]});
        rem_nxt[s][k] = ge_nxt[s][k] ? t - {1'b0, dmagd_r[s]} : t;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zerod_r[0] <= zero5_r;
      dmagd_r[0] <= dmag5_r;
      for (int k = 0; k < N_ENT; k++) begin
        ovfd_r[0][k] <= ({{(DET_W-COF_W){1'b0}}, mag5_r[k]} >= dmag5_r);
        remd_r[0][k] <= rem_t'(mag5_r[k]);
        quod_r[0][k] <= '0;
        negd_r[0][k] <= neg5_r[k];
      end
      for (int s = 0; s < QUO_W; s++) begin
        zerod_r[s+1] <= zerod_r[s];
        dmagd_r[s+1] <= dmagd_r[s];
        for (int k = 0; k < N_ENT; k++) begin
          ovfd_r[s+1][k] <= ovfd_r[s][k];
          negd_r[s+1][k] <= negd_r[s][k];
          remd_r[s+1][k] <= rem_nxt[s][k];
          quod_r[s+1][k] <= {quod_r[s][k][QUO_W-2:0], ge_nxt[s][k]};
        end
      end
    end
  end

  // saturate, sign and zero for singular
  always_comb begin
    quo_t q;
    logic sat;
    for (int k = 0; k < N_ENT; k++) begin
      q   = quod_r[QUO_W][k];
      sat = ovfd_r[QUO_W][k] ||
            (negd_r[QUO_W][k] ? (q > quo_t'(SAT_NEG)) : q[QUO_W-1]);
      if (zerod_r[QUO_W])
        res_nxt[k] = '0;
      else if (sat)
        res_nxt[k] = negd_r[QUO_W][k] ? SAT_NEG : SAT_POS;
      else
        res_nxt[k] = negd_r[QUO_W][k] ? ent_t'(-q) : ent_t'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r          <= res_nxt;
      out_singular_r <= zerod_r[QUO_W];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_singular      = out_singular_r;
  assign out_inv_col0_row0 = res_r[0];
  assign out_inv_col0_row1 = res_r[1];
  assign out_inv_col0_row2 = res_r[2];
  assign out_inv_col1_row0 = res_r[3];
  assign out_inv_col1_row1 = res_r[4];
  assign out_inv_col1_row2 = res_r[5];
  assign out_inv_col2_row0 = res_r[6];
  assign out_inv_col2_row1 = res_r[7];
  assign out_inv_col2_row2 = res_r[8];

endmodule
